/* sv/multi_level_priority_queue_core_assert.svh */
// Assertion macros used by the priority queue checker.
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MLPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mlpq_pkg.sv */
// Package for the multi-level priority queue: types, codes and defaults.
package mlpq_pkg;

    localparam int LEVELS_DEF      = 5;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int VALUE_W         = 16;
    localparam int PRIO_W          = 3;

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BAD_PRIO = 2'd3
    } t_status;

    // Access request to the entry store
    typedef struct packed {
        logic wr;
        logic rd;
    } t_store_cmd;

endpackage

/* sv/mlpq_store.sv */
// Entry store of the priority queue: one write or one read port, registered read data.
module mlpq_store import mlpq_pkg::*; #(
    parameter int ENTRIES = LEVELS_DEF * LEVEL_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  t_store_cmd                i_cmd,
    input  logic [$clog2(ENTRIES)-1:0] i_addr,
    input  logic [VALUE_W-1:0]        i_wdata,
    output logic [VALUE_W-1:0]        o_rdata
);

    logic [VALUE_W-1:0] r_mem [ENTRIES];
    logic [VALUE_W-1:0] r_rdata;

    // Write on insert, read on remove; at most one per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/multi_level_priority_queue_core.sv */
// Top level of the multi-level strict-priority queue.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_kind, i_item_value, i_priority_req
//  out     | o_out_valid | i_out_ready | o_status, o_removed_value, o_removed_level
//
// One item per cycle while the output is not stalled; each result appears in the cycle after its item is taken.
// The level select is a priority encoder over the per-level counts, and the
// single-port entry store serves the one write or read of each item.
// Reset clears head, tail and count of every level; the store is not cleared.
// The input takes a beat whenever the result register is empty or its beat
// is taken in the same cycle.
module multi_level_priority_queue_core import mlpq_pkg::*; #(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic signed [VALUE_W-1:0] i_item_value,
    input  logic [PRIO_W-1:0]         i_priority_req,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic signed [VALUE_W-1:0] o_removed_value,
    output logic [PRIO_W-1:0]         o_removed_level
);

    localparam int LVL_W   = $clog2(LEVELS);
    localparam int PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int ENTRIES = LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);

    // Per-level ring pointers and fill counts
    logic [PTR_W-1:0] r_head  [LEVELS];
    logic [PTR_W-1:0] r_tail  [LEVELS];
    logic [CNT_W-1:0] r_count [LEVELS];
    logic [PTR_W-1:0] n_head  [LEVELS];
    logic [PTR_W-1:0] n_tail  [LEVELS];
    logic [CNT_W-1:0] n_count [LEVELS];

    // Result register
    logic             r_out_valid;
    t_status          r_status;
    logic             r_pop;
    logic [LVL_W-1:0] r_level;
    t_status          n_status;
    logic             n_pop;
    logic [LVL_W-1:0] n_level;

    logic               w_accept;
    logic               w_prio_ok;
    logic [LVL_W-1:0]   w_ins_lvl;
    logic [LVL_W-1:0]   w_pop_lvl;
    logic               w_any;
    t_store_cmd         w_cmd;
    logic [ADDR_W-1:0]  w_addr;
    logic [VALUE_W-1:0] w_rdata;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_prio_ok  = int'(i_priority_req) < LEVELS;
    assign w_ins_lvl  = i_priority_req[LVL_W-1:0];

    // Lowest-numbered non-empty level
    always_comb begin
        w_pop_lvl = '0;
        w_any     = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                w_pop_lvl = LVL_W'(l);
                w_any     = 1'b1;
            end
        end
    end

    // Operation decode, pointer updates and store request
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = ST_OK;
        n_pop    = 1'b0;
        n_level  = '0;
        w_cmd    = '0;
        w_addr   = '0;
        if (w_accept) begin
            if (t_kind'(i_kind) == KIND_INSERT) begin
                if (!w_prio_ok) begin
                    n_status = ST_BAD_PRIO;
                end else if (r_count[w_ins_lvl] == CNT_W'(LEVEL_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.wr = 1'b1;
                    w_addr   = ADDR_W'(w_ins_lvl) * ADDR_W'(LEVEL_DEPTH)
                             + ADDR_W'(r_tail[w_ins_lvl]);
                    n_tail[w_ins_lvl]  = (r_tail[w_ins_lvl] == PTR_W'(LEVEL_DEPTH - 1))
                                       ? '0 : r_tail[w_ins_lvl] + 1'b1;
                    n_count[w_ins_lvl] = r_count[w_ins_lvl] + 1'b1;
                end
            end else begin
                if (!w_any) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_cmd.rd = 1'b1;
                    w_addr   = ADDR_W'(w_pop_lvl) * ADDR_W'(LEVEL_DEPTH)
                             + ADDR_W'(r_head[w_pop_lvl]);
                    n_head[w_pop_lvl]  = (r_head[w_pop_lvl] == PTR_W'(LEVEL_DEPTH - 1))
                                       ? '0 : r_head[w_pop_lvl] + 1'b1;
                    n_count[w_pop_lvl] = r_count[w_pop_lvl] - 1'b1;
                    n_pop   = 1'b1;
                    n_level = w_pop_lvl;
                end
            end
        end
    end

    // Level state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_pop    <= n_pop;
            r_level  <= n_level;
        end
    end

    mlpq_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_addr  (w_addr),
        .i_wdata (i_item_value),
        .o_rdata (w_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_pop ? signed'(w_rdata) : '0;
    assign o_removed_level = PRIO_W'(r_level);

endmodule

/* sv/mlpq_checker.sv */
// Port-level checker for the priority queue, bound to the top level.
`include "multi_level_priority_queue_core_assert.svh"

module mlpq_checker import mlpq_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      i_kind,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                o_status,
    input logic signed [VALUE_W-1:0] o_removed_value,
    input logic [PRIO_W-1:0]         o_removed_level
);

    logic w_in_beat;
    assign w_in_beat = i_in_valid && o_in_ready;

    // Every accepted beat leaves a result behind
    `MLPQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_rst_n && w_in_beat, o_out_valid, "no result after accepted beat")

    // An insert never reports empty, a remove never reports full or bad priority
    `MLPQ_ASSERT_NEXT(a_insert_status, i_clk, i_rst_n, i_rst_n && w_in_beat && i_kind == KIND_INSERT, o_status != ST_EMPTY, "insert reported empty")
    `MLPQ_ASSERT_NEXT(a_remove_status, i_clk, i_rst_n, i_rst_n && w_in_beat && i_kind == KIND_REMOVE, o_status == ST_OK || o_status == ST_EMPTY, "remove reported insert error")

    // Failed operations return zero fields; a pop names an existing level
    `MLPQ_ASSERT_SAME(a_error_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_removed_value == 0 && o_removed_level == 0, "nonzero fields on failed operation")
    `MLPQ_ASSERT_SAME(a_level_range, i_clk, i_rst_n, o_out_valid, int'(o_removed_level) < LEVELS, "removed level out of range")

endmodule

bind multi_level_priority_queue_core mlpq_checker #(
    .LEVELS (LEVELS)
) u_mlpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_kind          (i_kind),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_removed_value (o_removed_value),
    .o_removed_level (o_removed_level)
);
